>>> rtl/tblb_pkg.sv
// Shared constants, codes and types of the terminal byte line buffer.
package tblb_pkg;

	localparam int HISTORY_LINES = 100;
	localparam int LINE_WIDTH = 160;
	localparam int SLOTS = HISTORY_LINES + 1;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int STORE_DEPTH = SLOTS * LINE_WIDTH;
	localparam int STORE_AW = $clog2(STORE_DEPTH);

	localparam int BYTE_W = 8;
	localparam int ROW_W = 7;
	localparam int LEN_W = 8;
	localparam int ACT_W = 3;

	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [BYTE_W-1:0] CHAR_BS = 8'h08;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_ESC = 8'h1B;
	localparam logic [BYTE_W-1:0] CHAR_LBRACKET = 8'h5B;
	localparam logic [BYTE_W-1:0] CHAR_J = 8'h4A;
	localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
	localparam logic [BYTE_W-1:0] CSI_FINAL_LO = 8'h40;
	localparam logic [BYTE_W-1:0] CSI_FINAL_HI = 8'h7E;

	typedef enum logic [ACT_W-1:0] {
		ACT_IGNORED = 3'd0,
		ACT_APPENDED = 3'd1,
		ACT_COMMITTED = 3'd2,
		ACT_WRAPPED = 3'd3,
		ACT_CLEARED = 3'd4,
		ACT_BACKSPACE = 3'd5,
		ACT_READ_OK = 3'd6,
		ACT_READ_INVALID = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		ESC_NORMAL = 2'd0,
		ESC_AFTER = 2'd1,
		ESC_CSI = 2'd2
	} esc_mode_t;

	typedef enum logic [2:0] {
		CMD_NOP = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_COMMIT = 3'd2,
		CMD_BACKSPACE = 3'd3,
		CMD_CLEAR = 3'd4,
		CMD_READ = 3'd5
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [BYTE_W-1:0] data;
		logic [ROW_W-1:0] row;
		logic [LEN_W-1:0] column;
	} cmd_t;

	typedef struct packed {
		act_t action;
		logic [BYTE_W-1:0] char_out;
		logic [ROW_W-1:0] line_total;
		logic [LEN_W-1:0] live_length;
		logic [LEN_W-1:0] row_length;
	} result_t;

endpackage

>>> rtl/tblb_in_if.sv
// Input channel: one feed or read request per transaction.
interface tblb_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [tblb_pkg::BYTE_W-1:0] byte_value;
	logic [tblb_pkg::ROW_W-1:0] row;
	logic [tblb_pkg::LEN_W-1:0] column;

	modport source (output valid, output op, output byte_value, output row, output column,
		input ready);
	modport sink (input valid, input op, input byte_value, input row, input column,
		output ready);
endinterface

>>> rtl/tblb_out_if.sv
// Output channel: one result per transaction.
interface tblb_out_if;
	logic valid;
	logic ready;
	logic [tblb_pkg::ACT_W-1:0] action;
	logic [tblb_pkg::BYTE_W-1:0] char_out;
	logic [tblb_pkg::ROW_W-1:0] line_total;
	logic [tblb_pkg::LEN_W-1:0] live_length;
	logic [tblb_pkg::LEN_W-1:0] row_length;

	modport source (output valid, output action, output char_out, output line_total,
		output live_length, output row_length, input ready);
	modport sink (input valid, input action, input char_out, input line_total,
		input live_length, input row_length, output ready);
endinterface

>>> rtl/tblb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tblb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/tblb_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module tblb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] push_data,
	input logic pop,
	output logic [WIDTH-1:0] pop_data,
	output logic [CW-1:0] count,
	output logic full,
	output logic empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_next(rd_q);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign pop_data = mem_q[rd_q];
	assign count = count_q;
	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

endmodule

>>> rtl/tblb_front.sv
// Front end: accepts requests, tracks escape sequences and classifies each byte.
module tblb_front (
	input logic clk,
	input logic arst_n,
	tblb_in_if.sink item,
	input logic q_full,
	output logic q_push,
	output tblb_pkg::cmd_t q_cmd
);

	tblb_pkg::esc_mode_t esc_q;
	tblb_pkg::esc_mode_t esc_d;
	tblb_pkg::cmd_kind_t kind;
	logic accept;

	assign item.ready = !q_full;
	assign accept = item.valid && !q_full;

	always_comb begin
		esc_d = esc_q;
		if (item.op == tblb_pkg::OP_FEED) begin
			case (esc_q)
				tblb_pkg::ESC_NORMAL: begin
					if (item.byte_value == tblb_pkg::CHAR_ESC) begin
						esc_d = tblb_pkg::ESC_AFTER;
					end
				end
				tblb_pkg::ESC_AFTER: begin
					esc_d = (item.byte_value == tblb_pkg::CHAR_LBRACKET) ?
						tblb_pkg::ESC_CSI : tblb_pkg::ESC_NORMAL;
				end
				tblb_pkg::ESC_CSI: begin
					if (item.byte_value inside
						{[tblb_pkg::CSI_FINAL_LO:tblb_pkg::CSI_FINAL_HI]}) begin
						esc_d = tblb_pkg::ESC_NORMAL;
					end
				end
				default: begin
					esc_d = tblb_pkg::ESC_NORMAL;
				end
			endcase
		end
	end

	always_comb begin
		kind = tblb_pkg::CMD_NOP;
		if (item.op == tblb_pkg::OP_READ) begin
			kind = tblb_pkg::CMD_READ;
		end else begin
			case (esc_q)
				tblb_pkg::ESC_NORMAL: begin
					if (item.byte_value == tblb_pkg::CHAR_LF) begin
						kind = tblb_pkg::CMD_COMMIT;
					end else if (item.byte_value == tblb_pkg::CHAR_BS) begin
						kind = tblb_pkg::CMD_BACKSPACE;
					end else if (item.byte_value inside
						{[tblb_pkg::PRINT_LO:tblb_pkg::PRINT_HI]}) begin
						kind = tblb_pkg::CMD_APPEND;
					end
				end
				tblb_pkg::ESC_CSI: begin
					if (item.byte_value == tblb_pkg::CHAR_J) begin
						kind = tblb_pkg::CMD_CLEAR;
					end
				end
				default: begin
					kind = tblb_pkg::CMD_NOP;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= tblb_pkg::ESC_NORMAL;
		end else if (accept) begin
			esc_q <= esc_d;
		end
	end

	assign q_push = accept;
	assign q_cmd = '{kind: kind, data: item.byte_value, row: item.row, column: item.column};

endmodule

>>> rtl/tblb_back.sv
// Back end: line ring pointers, line storage and the read stage.
module tblb_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input tblb_pkg::cmd_t cmd,
	output logic cmd_pop,
	input logic [tblb_pkg::OUT_CW-1:0] out_count,
	output logic res_push,
	output tblb_pkg::result_t res
);

	localparam int SW = tblb_pkg::SLOT_W;
	localparam int LW = tblb_pkg::LEN_W;
	localparam int RW = tblb_pkg::ROW_W;

	logic [LW-1:0] live_q, live_d;
	logic [RW-1:0] total_q, total_d;
	logic [SW-1:0] head_q, head_d;
	logic [SW-1:0] lslot_q, lslot_d;

	tblb_pkg::act_t act_d;
	logic issue;
	logic credit_ok;
	logic len_we;
	logic st_we;
	logic read_ok_d;
	logic from_ram_d;
	logic [SW-1:0] acc_slot;
	logic [LW-1:0] acc_col;
	logic [tblb_pkg::STORE_AW-1:0] acc_addr;
	logic [SW:0] row_sum;
	logic [SW-1:0] row_slot;
	logic [LW-1:0] len_rdata;
	logic [tblb_pkg::BYTE_W-1:0] st_rdata;

	logic valid_s1;
	tblb_pkg::act_t act_s1;
	logic [RW-1:0] total_s1;
	logic [LW-1:0] live_s1;
	logic read_ok_s1;
	logic from_ram_s1;
	logic [LW-1:0] len_s1;
	logic [LW-1:0] col_s1;
	logic [LW-1:0] row_len;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(tblb_pkg::SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	assign credit_ok = (int'(out_count) + int'(valid_s1)) < tblb_pkg::OUT_DEPTH;
	assign issue = cmd_valid && credit_ok;
	assign cmd_pop = issue;

	assign row_sum = {1'b0, head_q} + (SW + 1)'(cmd.row);
	assign row_slot = (row_sum >= (SW + 1)'(tblb_pkg::SLOTS)) ?
		SW'(row_sum - (SW + 1)'(tblb_pkg::SLOTS)) : SW'(row_sum);

	always_comb begin
		act_d = tblb_pkg::ACT_IGNORED;
		live_d = live_q;
		total_d = total_q;
		head_d = head_q;
		lslot_d = lslot_q;
		len_we = 1'b0;
		st_we = 1'b0;
		read_ok_d = 1'b0;
		from_ram_d = 1'b0;
		acc_slot = lslot_q;
		acc_col = live_q;
		case (cmd.kind)
			tblb_pkg::CMD_APPEND: begin
				st_we = 1'b1;
				if ((int'(live_q) + 1) >= tblb_pkg::LINE_WIDTH) begin
					len_we = 1'b1;
					lslot_d = slot_inc(lslot_q);
					if (total_q == RW'(tblb_pkg::HISTORY_LINES)) begin
						head_d = slot_inc(head_q);
					end else begin
						total_d = total_q + 1'b1;
					end
					acc_slot = slot_inc(lslot_q);
					acc_col = '0;
					live_d = LW'(1);
					act_d = tblb_pkg::ACT_WRAPPED;
				end else begin
					live_d = live_q + 1'b1;
					act_d = tblb_pkg::ACT_APPENDED;
				end
			end
			tblb_pkg::CMD_COMMIT: begin
				len_we = 1'b1;
				lslot_d = slot_inc(lslot_q);
				if (total_q == RW'(tblb_pkg::HISTORY_LINES)) begin
					head_d = slot_inc(head_q);
				end else begin
					total_d = total_q + 1'b1;
				end
				live_d = '0;
				act_d = tblb_pkg::ACT_COMMITTED;
			end
			tblb_pkg::CMD_BACKSPACE: begin
				if (live_q != '0) begin
					live_d = live_q - 1'b1;
					act_d = tblb_pkg::ACT_BACKSPACE;
				end
			end
			tblb_pkg::CMD_CLEAR: begin
				live_d = '0;
				total_d = '0;
				head_d = '0;
				lslot_d = '0;
				act_d = tblb_pkg::ACT_CLEARED;
			end
			tblb_pkg::CMD_READ: begin
				acc_col = (int'(cmd.column) < tblb_pkg::LINE_WIDTH) ? cmd.column : '0;
				if (cmd.row < total_q) begin
					acc_slot = row_slot;
					read_ok_d = 1'b1;
					from_ram_d = 1'b1;
					act_d = tblb_pkg::ACT_READ_OK;
				end else if (cmd.row == total_q) begin
					read_ok_d = 1'b1;
					act_d = tblb_pkg::ACT_READ_OK;
				end else begin
					act_d = tblb_pkg::ACT_READ_INVALID;
				end
			end
			default: begin
				act_d = tblb_pkg::ACT_IGNORED;
			end
		endcase
	end

	assign acc_addr = tblb_pkg::STORE_AW'(int'(acc_slot) * tblb_pkg::LINE_WIDTH + int'(acc_col));

	tblb_ram #(
		.WIDTH(tblb_pkg::BYTE_W),
		.DEPTH(tblb_pkg::STORE_DEPTH)
	) u_store (
		.clk(clk),
		.we(issue && st_we),
		.waddr(acc_addr),
		.wdata(cmd.data),
		.raddr(acc_addr),
		.rdata(st_rdata)
	);

	tblb_ram #(
		.WIDTH(LW),
		.DEPTH(tblb_pkg::SLOTS)
	) u_lengths (
		.clk(clk),
		.we(issue && len_we),
		.waddr(lslot_q),
		.wdata(live_q),
		.raddr(acc_slot),
		.rdata(len_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			total_q <= '0;
			head_q <= '0;
			lslot_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				live_q <= live_d;
				total_q <= total_d;
				head_q <= head_d;
				lslot_q <= lslot_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			act_s1 <= act_d;
			total_s1 <= total_d;
			live_s1 <= live_d;
			read_ok_s1 <= read_ok_d;
			from_ram_s1 <= from_ram_d;
			len_s1 <= live_q;
			col_s1 <= cmd.column;
		end
	end

	always_comb begin
		row_len = '0;
		if (read_ok_s1) begin
			row_len = from_ram_s1 ? len_rdata : len_s1;
		end
		res.action = act_s1;
		res.char_out = (read_ok_s1 && (col_s1 < row_len)) ? st_rdata : '0;
		res.line_total = total_s1;
		res.live_length = live_s1;
		res.row_length = row_len;
	end

	assign res_push = valid_s1;

endmodule

>>> rtl/terminal_byte_line_buffer.sv
// Top level of the terminal byte line buffer: front end, command queue, back end, result queue.
// A result passes the command queue, back-end read stage and result queue; stalls delay it.
// Throughput: one request per cycle, set by one store access each, while results drain.
// Reset clears the escape state, the line counters and ring pointers, and both queues.
// The line store and the length store are not cleared; entries are only read once written.
module terminal_byte_line_buffer (
	input logic clk,
	input logic arst_n,
	tblb_in_if.sink item,
	tblb_out_if.source result
);

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	tblb_pkg::cmd_t q_cmd;
	tblb_pkg::cmd_t q_head;

	logic res_push;
	logic res_pop;
	logic res_empty;
	logic [tblb_pkg::OUT_CW-1:0] res_count;
	tblb_pkg::result_t res;
	tblb_pkg::result_t res_head;

	tblb_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	tblb_fifo #(
		.WIDTH($bits(tblb_pkg::cmd_t)),
		.DEPTH(tblb_pkg::CMD_DEPTH)
	) u_cmd_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_cmd),
		.pop(q_pop),
		.pop_data(q_head),
		.count(),
		.full(q_full),
		.empty(q_empty)
	);

	tblb_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(!q_empty),
		.cmd(q_head),
		.cmd_pop(q_pop),
		.out_count(res_count),
		.res_push(res_push),
		.res(res)
	);

	tblb_fifo #(
		.WIDTH($bits(tblb_pkg::result_t)),
		.DEPTH(tblb_pkg::OUT_DEPTH)
	) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.push_data(res),
		.pop(res_pop),
		.pop_data(res_head),
		.count(res_count),
		.full(),
		.empty(res_empty)
	);

	assign result.valid = !res_empty;
	assign res_pop = result.valid && result.ready;
	assign result.action = res_head.action;
	assign result.char_out = res_head.char_out;
	assign result.line_total = res_head.line_total;
	assign result.live_length = res_head.live_length;
	assign result.row_length = res_head.row_length;

endmodule

>>> rtl/tblb_checker.sv
// Port-level checker for the terminal byte line buffer and its bind to the top level.
module tblb_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [tblb_pkg::ACT_W-1:0] action,
	input logic [tblb_pkg::BYTE_W-1:0] char_out,
	input logic [tblb_pkg::ROW_W-1:0] line_total,
	input logic [tblb_pkg::LEN_W-1:0] live_length,
	input logic [tblb_pkg::LEN_W-1:0] row_length
);

	logic in_fire;
	logic out_fire;
	logic is_read;
	logic [3:0] open_q;
	logic have_prev_q;
	logic [tblb_pkg::ROW_W-1:0] prev_total_q;
	logic [tblb_pkg::LEN_W-1:0] prev_live_q;

	assign in_fire = item_valid && item_ready;
	assign out_fire = out_valid && out_ready;
	assign is_read = (action == tblb_pkg::ACT_READ_OK) || (action == tblb_pkg::ACT_READ_INVALID);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			have_prev_q <= 1'b0;
			prev_total_q <= '0;
			prev_live_q <= '0;
		end else begin
			open_q <= open_q + 4'(in_fire) - 4'(out_fire);
			if (out_fire) begin
				have_prev_q <= 1'b1;
				prev_total_q <= line_total;
				prev_live_q <= live_length;
			end
		end
	end

	// Every result must belong to a transaction taken earlier.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (open_q != '0))
		else $error("result delivered with no request outstanding");

	// Outside a clear, the committed line count grows by at most one per result.
	a_total_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && have_prev_q && (action != tblb_pkg::ACT_CLEARED)) |->
		((line_total >= prev_total_q) &&
		({1'b0, line_total} <= ({1'b0, prev_total_q} + 1'b1))))
		else $error("line count moved by more than one line");

	// A read leaves the line counts as the previous result reported them.
	a_read_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && have_prev_q && is_read) |->
		((line_total == prev_total_q) && (live_length == prev_live_q)))
		else $error("read changed the buffer state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		(out_valid && $stable(action) && $stable(char_out) && $stable(line_total) &&
		$stable(live_length) && $stable(row_length)))
		else $error("stalled result changed");

endmodule

bind terminal_byte_line_buffer tblb_checker u_tblb_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.action(result.action),
	.char_out(result.char_out),
	.line_total(result.line_total),
	.live_length(result.live_length),
	.row_length(result.row_length)
);

>>> test/testbench.sv
// Self-checking testbench for the terminal byte line buffer: random byte streams, reads, checks.
class terminal_history_checker;
	logic [tblb_pkg::BYTE_W-1:0] history [tblb_pkg::HISTORY_LINES][tblb_pkg::LINE_WIDTH];
	logic [tblb_pkg::LEN_W-1:0] history_len [tblb_pkg::HISTORY_LINES];
	logic [tblb_pkg::BYTE_W-1:0] live_chars [tblb_pkg::LINE_WIDTH];
	tblb_pkg::esc_mode_t esc_mode;
	int live_size;
	int held_lines;
	int oldest_slot;
	tblb_pkg::result_t awaited[$];
	int errors;
	int requests;
	int results;
	int overwrites;
	int action_seen [8];

	function new();
		esc_mode = tblb_pkg::ESC_NORMAL;
		live_size = 0;
		held_lines = 0;
		oldest_slot = 0;
		errors = 0;
		requests = 0;
		results = 0;
		overwrites = 0;
		foreach (action_seen[i]) action_seen[i] = 0;
	endfunction

	function void store_live_line();
		int slot;
		if (held_lines >= tblb_pkg::HISTORY_LINES) begin
			slot = oldest_slot;
			oldest_slot = (oldest_slot + 1) % tblb_pkg::HISTORY_LINES;
			overwrites++;
		end else begin
			slot = (oldest_slot + held_lines) % tblb_pkg::HISTORY_LINES;
			held_lines++;
		end
		for (int i = 0; i < live_size; i++) history[slot][i] = live_chars[i];
		history_len[slot] = tblb_pkg::LEN_W'(live_size);
		live_size = 0;
	endfunction

	function tblb_pkg::act_t feed(logic [tblb_pkg::BYTE_W-1:0] b);
		tblb_pkg::act_t act;
		if (esc_mode == tblb_pkg::ESC_AFTER) begin
			esc_mode = (b == tblb_pkg::CHAR_LBRACKET) ? tblb_pkg::ESC_CSI : tblb_pkg::ESC_NORMAL;
			return tblb_pkg::ACT_IGNORED;
		end
		if (esc_mode == tblb_pkg::ESC_CSI) begin
			if (b >= tblb_pkg::CSI_FINAL_LO && b <= tblb_pkg::CSI_FINAL_HI) begin
				esc_mode = tblb_pkg::ESC_NORMAL;
				if (b == tblb_pkg::CHAR_J) begin
					held_lines = 0;
					live_size = 0;
					oldest_slot = 0;
					return tblb_pkg::ACT_CLEARED;
				end
			end
			return tblb_pkg::ACT_IGNORED;
		end
		if (b == tblb_pkg::CHAR_ESC) begin
			esc_mode = tblb_pkg::ESC_AFTER;
			return tblb_pkg::ACT_IGNORED;
		end
		if (b == tblb_pkg::CHAR_CR)
			return tblb_pkg::ACT_IGNORED;
		if (b == tblb_pkg::CHAR_LF) begin
			store_live_line();
			return tblb_pkg::ACT_COMMITTED;
		end
		if (b == tblb_pkg::CHAR_BS) begin
			if (live_size == 0)
				return tblb_pkg::ACT_IGNORED;
			live_size--;
			return tblb_pkg::ACT_BACKSPACE;
		end
		if (b < tblb_pkg::PRINT_LO || b > tblb_pkg::PRINT_HI)
			return tblb_pkg::ACT_IGNORED;
		act = tblb_pkg::ACT_APPENDED;
		if (live_size + 1 >= tblb_pkg::LINE_WIDTH) begin
			store_live_line();
			act = tblb_pkg::ACT_WRAPPED;
		end
		live_chars[live_size] = b;
		live_size++;
		return act;
	endfunction

	function int row_length_of(int row_i);
		int slot;
		if (row_i < held_lines) begin
			slot = (oldest_slot + row_i) % tblb_pkg::HISTORY_LINES;
			return history_len[slot];
		end
		if (row_i == held_lines)
			return live_size;
		return 0;
	endfunction

	function tblb_pkg::act_t note_request(logic op_i, logic [tblb_pkg::BYTE_W-1:0] b,
		logic [tblb_pkg::ROW_W-1:0] row_i, logic [tblb_pkg::LEN_W-1:0] col_i);
		tblb_pkg::result_t r;
		int slot;
		int len;
		r.char_out = '0;
		len = 0;
		if (op_i == tblb_pkg::OP_FEED) begin
			r.action = feed(b);
		end else if (row_i < held_lines) begin
			slot = (oldest_slot + row_i) % tblb_pkg::HISTORY_LINES;
			len = history_len[slot];
			if (col_i < len)
				r.char_out = history[slot][col_i];
			r.action = tblb_pkg::ACT_READ_OK;
		end else if (row_i == held_lines) begin
			len = live_size;
			if (col_i < len)
				r.char_out = live_chars[col_i];
			r.action = tblb_pkg::ACT_READ_OK;
		end else begin
			r.action = tblb_pkg::ACT_READ_INVALID;
		end
		r.line_total = tblb_pkg::ROW_W'(held_lines);
		r.live_length = tblb_pkg::LEN_W'(live_size);
		r.row_length = tblb_pkg::LEN_W'(len);
		awaited.push_back(r);
		requests++;
		action_seen[r.action]++;
		return r.action;
	endfunction

	function void check_result(tblb_pkg::result_t got);
		tblb_pkg::result_t want;
		results++;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("Mismatch: result with action %0d arrived while none was expected",
					got.action);
			return;
		end
		want = awaited.pop_front();
		if (got.action !== want.action || got.char_out !== want.char_out ||
			got.line_total !== want.line_total || got.live_length !== want.live_length ||
			got.row_length !== want.row_length) begin
			errors++;
			if (errors <= 10)
				$display({"Mismatch on result %0d: expected action %0d char %0h lines %0d ",
					"live %0d row_len %0d, got action %0d char %0h lines %0d live %0d ",
					"row_len %0d"}, results, want.action, want.char_out, want.line_total,
					want.live_length, want.row_length, got.action, got.char_out,
					got.line_total, got.live_length, got.row_length);
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1850;
	localparam int CYCLE_LIMIT = 600000;
	localparam int BACKLOG_AT = 400;
	localparam int BACKLOG_CYCLES = 250;

	logic clk;
	logic arst_n;
	int cycle_count;
	int useful_items;
	int send_steady;
	int results_seen;

	tblb_in_if item_ch();
	tblb_out_if result_ch();

	terminal_history_checker sb;

	terminal_byte_line_buffer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				sb.awaited.size());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int pick_send_gap();
		int r;
		if (send_steady > 0) begin
			send_steady--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5)
			send_steady = $urandom_range(10, 60);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic op_i, input logic [tblb_pkg::BYTE_W-1:0] b,
		input logic [tblb_pkg::ROW_W-1:0] row_i, input logic [tblb_pkg::LEN_W-1:0] col_i);
		int gap;
		tblb_pkg::act_t act;
		gap = pick_send_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= op_i;
		item_ch.byte_value <= b;
		item_ch.row <= row_i;
		item_ch.column <= col_i;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		act = sb.note_request(op_i, b, row_i, col_i);
		if (act != tblb_pkg::ACT_IGNORED)
			useful_items++;
	endtask

	task automatic feed_byte(input logic [tblb_pkg::BYTE_W-1:0] b);
		send_item(tblb_pkg::OP_FEED, b, tblb_pkg::ROW_W'($urandom_range(0, 127)),
			tblb_pkg::LEN_W'($urandom_range(0, 255)));
	endtask

	task automatic read_char(input int row_i, input int col_i);
		send_item(tblb_pkg::OP_READ, tblb_pkg::BYTE_W'($urandom_range(0, 255)),
			tblb_pkg::ROW_W'(row_i), tblb_pkg::LEN_W'(col_i));
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.awaited.size() != 0);
	endtask

	task automatic emit_text_line();
		int len;
		int r;
		if ($urandom_range(0, 99) < 5)
			len = $urandom_range(150, 330);
		else
			len = $urandom_range(0, 12);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0)
				feed_byte(tblb_pkg::CHAR_BS);
			else
				feed_byte(tblb_pkg::BYTE_W'($urandom_range(tblb_pkg::PRINT_LO,
					tblb_pkg::PRINT_HI)));
		end
		r = $urandom_range(0, 99);
		if (r < 5)
			feed_byte(tblb_pkg::CHAR_CR);
		if (r < 90)
			feed_byte(tblb_pkg::CHAR_LF);
	endtask

	task automatic emit_read();
		int row_i;
		int len;
		int col_i;
		if ($urandom_range(0, 9) == 0)
			row_i = $urandom_range(0, 127);
		else
			row_i = $urandom_range(0, sb.held_lines);
		len = sb.row_length_of(row_i);
		if (len > 0 && $urandom_range(0, 3) != 0)
			col_i = $urandom_range(0, len - 1);
		else
			col_i = $urandom_range(0, 255);
		read_char(row_i, col_i);
	endtask

	task automatic emit_escape();
		int params;
		int clear_pct;
		feed_byte(tblb_pkg::CHAR_ESC);
		if ($urandom_range(0, 9) < 3) begin
			feed_byte(tblb_pkg::BYTE_W'($urandom_range(0, 255)));
		end else begin
			feed_byte(tblb_pkg::CHAR_LBRACKET);
			params = $urandom_range(0, 3);
			for (int i = 0; i < params; i++)
				feed_byte(tblb_pkg::BYTE_W'($urandom_range(8'h30, 8'h3F)));
			clear_pct = (sb.held_lines == tblb_pkg::HISTORY_LINES) ? 30 : 3;
			if ($urandom_range(0, 99) < clear_pct)
				feed_byte(tblb_pkg::CHAR_J);
			else
				feed_byte(tblb_pkg::BYTE_W'($urandom_range(tblb_pkg::CSI_FINAL_LO,
					tblb_pkg::CSI_FINAL_HI)));
		end
	endtask

	initial begin
		int hold_left;
		int stall_left;
		int steady_left;
		int r;
		tblb_pkg::result_t got;
		bit backlog_done;
		hold_left = 0;
		stall_left = 0;
		steady_left = 0;
		backlog_done = 0;
		results_seen = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got.action = tblb_pkg::act_t'(result_ch.action);
				got.char_out = result_ch.char_out;
				got.line_total = result_ch.line_total;
				got.live_length = result_ch.live_length;
				got.row_length = result_ch.row_length;
				sb.check_result(got);
				results_seen++;
			end
			if (!backlog_done && results_seen >= BACKLOG_AT) begin
				backlog_done = 1;
				hold_left = BACKLOG_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (steady_left > 0) begin
					steady_left--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 5)
						steady_left = $urandom_range(20, 100);
					else if (r < 60)
						stall_left = 0;
					else if (r < 92)
						stall_left = $urandom_range(1, 3);
					else if (r < 98)
						stall_left = $urandom_range(4, 10);
					else
						stall_left = $urandom_range(11, 40);
				end
			end
		end
	end

	initial begin
		int pick;
		bit paused_once;
		sb = new();
		cycle_count = 0;
		useful_items = 0;
		send_steady = 0;
		paused_once = 0;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.op <= tblb_pkg::OP_FEED;
		item_ch.byte_value <= '0;
		item_ch.row <= '0;
		item_ch.column <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		read_char(0, 0);
		read_char(127, 255);
		feed_byte(tblb_pkg::PRINT_LO);
		feed_byte(tblb_pkg::PRINT_HI);
		feed_byte(8'h1F);
		feed_byte(8'h7F);
		feed_byte(8'hFF);
		feed_byte(tblb_pkg::CHAR_CR);
		feed_byte(tblb_pkg::CHAR_BS);
		feed_byte(tblb_pkg::CHAR_BS);
		feed_byte(tblb_pkg::CHAR_BS);
		feed_byte(8'h41);
		feed_byte(tblb_pkg::CHAR_LF);
		read_char(0, 0);
		read_char(0, 200);
		read_char(1, 0);
		feed_byte(tblb_pkg::CHAR_ESC);
		feed_byte(8'h78);
		feed_byte(tblb_pkg::CHAR_ESC);
		feed_byte(tblb_pkg::CHAR_LBRACKET);
		feed_byte(8'h3F);
		feed_byte(8'h6D);
		feed_byte(tblb_pkg::CHAR_ESC);
		feed_byte(tblb_pkg::CHAR_LBRACKET);
		feed_byte(tblb_pkg::CHAR_J);
		read_char(0, 0);
		drain_results();

		useful_items = 0;
		while (useful_items < ITEM_TARGET) begin
			if (!paused_once && useful_items >= ITEM_TARGET / 2) begin
				paused_once = 1;
				drain_results();
			end
			pick = $urandom_range(0, 99);
			if (pick < 55)
				emit_text_line();
			else if (pick < 80)
				emit_read();
			else if (pick < 93)
				feed_byte(tblb_pkg::BYTE_W'($urandom_range(0, 255)));
			else
				emit_escape();
		end
		drain_results();
		repeat (20) @(posedge clk);

		$display("Run covered %0d transactions: %0d appends, %0d commits, %0d wraps, %0d clears,",
			sb.requests, sb.action_seen[tblb_pkg::ACT_APPENDED],
			sb.action_seen[tblb_pkg::ACT_COMMITTED], sb.action_seen[tblb_pkg::ACT_WRAPPED],
			sb.action_seen[tblb_pkg::ACT_CLEARED]);
		$display("%0d backspaces, %0d reads, %0d invalid reads, %0d ring overwrites, %0d errors.",
			sb.action_seen[tblb_pkg::ACT_BACKSPACE], sb.action_seen[tblb_pkg::ACT_READ_OK],
			sb.action_seen[tblb_pkg::ACT_READ_INVALID], sb.overwrites, sb.errors);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
